// ===== src/lmtc_pkg.sv =====
// Shared types and timing constants for the LCD mode timing controller.
// Used by every module of the block; no dependencies.
`default_nettype none
package lmtc_pkg;

	localparam int LineDotsW  = 9;
	localparam int FrameDotsW = 17;
	localparam int LineW      = 8;

	localparam logic [LineDotsW-1:0]  DotDrawStart    = 9'd80;
	localparam logic [LineDotsW-1:0]  DotDrawEnd      = 9'd252;
	localparam logic [LineDotsW-1:0]  DotsPerLine     = 9'd456;
	localparam logic [LineW-1:0]      FirstVblankLine = 8'd144;
	localparam logic [FrameDotsW-1:0] DotsPerFrame    = 17'd70224;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} lmtc_mode_t;

	typedef enum logic [1:0] {
		REG_COMPARE_LINE = 2'd0,
		REG_STAT_ENABLES = 2'd1,
		REG_WINDOW_TOP   = 2'd2
	} lmtc_reg_t;

	localparam int EnHblank = 0;
	localparam int EnVblank = 1;
	localparam int EnOam    = 2;
	localparam int EnMatch  = 3;

	typedef struct packed {
		logic advance;
		logic display_enabled;
	} lmtc_tick_t;

	typedef struct packed {
		lmtc_mode_t       current_mode;
		logic [LineW-1:0] current_line;
		logic             line_match;
		logic             stat_interrupt;
		logic             vblank_interrupt;
		logic             render_line;
		logic             frame_done;
		logic             window_latched;
	} lmtc_result_t;

endpackage
`default_nettype wire

// ===== src/lmtc_in_stage.sv =====
// Input register for the dot tick channel.
// Depends on lmtc_pkg.
`default_nettype none
module lmtc_in_stage
	import lmtc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire lmtc_tick_t tick,
	input  wire logic       take,
	output logic            valid_s1,
	output lmtc_tick_t      tick_s1
);

	logic load;

	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tick_s1 <= tick;
		end
	end

endmodule
`default_nettype wire

// ===== src/lmtc_seq.sv =====
// Mode sequencer: configuration registers, dot and line counters, status evaluation.
// Depends on lmtc_pkg.
`default_nettype none
module lmtc_seq
	import lmtc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [LineW-1:0] cfg_data,
	input  wire logic             step,
	input  wire lmtc_tick_t       tick_s1,
	output lmtc_result_t          result
);

	logic [LineW-1:0]      compare_line_q;
	logic [3:0]            stat_enables_q;
	logic [LineW-1:0]      window_top_q;

	lmtc_mode_t            mode_q, mode_n;
	logic [LineW-1:0]      line_q, line_n, line_inc;
	logic [LineDotsW-1:0]  line_dots_q, line_dots_n, ld_inc;
	logic [FrameDotsW-1:0] frame_dots_q, frame_dots_n, fd_inc;
	logic                  prev_stat_q, window_q, match_q;
	logic                  window_n;
	logic                  eval, match, cond, edge_hit;
	logic                  vblank_p, render_p, frame_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_line_q <= '0;
			stat_enables_q <= '0;
			window_top_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COMPARE_LINE: compare_line_q <= cfg_data;
				REG_STAT_ENABLES: stat_enables_q <= cfg_data[3:0];
				REG_WINDOW_TOP:   window_top_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ld_inc   = line_dots_q + LineDotsW'(1);
	assign fd_inc   = frame_dots_q + FrameDotsW'(1);
	assign line_inc = line_q + LineW'(1);

	always_comb begin
		mode_n       = mode_q;
		line_n       = line_q;
		line_dots_n  = line_dots_q;
		frame_dots_n = frame_dots_q;
		window_n     = window_q;
		eval         = 1'b0;
		vblank_p     = 1'b0;
		render_p     = 1'b0;
		frame_p      = 1'b0;
		if (!tick_s1.display_enabled) begin
			line_n       = '0;
			mode_n       = MODE_HBLANK;
			line_dots_n  = '0;
			frame_dots_n = '0;
			eval         = 1'b1;
		end else if (tick_s1.advance) begin
			line_dots_n  = ld_inc;
			frame_dots_n = fd_inc;
			case (mode_q)
				MODE_OAM: begin
					if (ld_inc == DotDrawStart) begin
						mode_n = MODE_DRAW;
						eval   = 1'b1;
						if (line_q == window_top_q) begin
							window_n = 1'b1;
						end
					end
				end
				MODE_DRAW: begin
					if (ld_inc == DotDrawEnd) begin
						render_p = 1'b1;
						mode_n   = MODE_HBLANK;
						eval     = 1'b1;
					end
				end
				MODE_HBLANK: begin
					if (ld_inc == DotsPerLine) begin
						line_dots_n = '0;
						line_n      = line_inc;
						if (line_inc == FirstVblankLine) begin
							vblank_p = 1'b1;
							mode_n   = MODE_VBLANK;
						end else begin
							mode_n = MODE_OAM;
						end
						eval = 1'b1;
					end
				end
				default: begin
					if (ld_inc == DotsPerLine) begin
						window_n    = 1'b0;
						line_dots_n = '0;
						line_n      = line_inc;
						if (fd_inc == DotsPerFrame) begin
							frame_p      = 1'b1;
							frame_dots_n = '0;
							line_n       = '0;
							mode_n       = MODE_OAM;
						end
						eval = 1'b1;
					end
				end
			endcase
		end
	end

	assign match = (compare_line_q == line_n);
	assign cond  = (match && stat_enables_q[EnMatch]) ||
	               (mode_n == MODE_OAM && stat_enables_q[EnOam]) ||
	               (mode_n == MODE_VBLANK && stat_enables_q[EnVblank]) ||
	               (mode_n == MODE_HBLANK && stat_enables_q[EnHblank]);
	assign edge_hit = eval && cond && !prev_stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OAM;
			line_q       <= '0;
			line_dots_q  <= '0;
			frame_dots_q <= '0;
			prev_stat_q  <= 1'b0;
			window_q     <= 1'b0;
			match_q      <= 1'b0;
		end else if (step) begin
			mode_q       <= mode_n;
			line_q       <= line_n;
			line_dots_q  <= line_dots_n;
			frame_dots_q <= frame_dots_n;
			window_q     <= window_n;
			if (eval) begin
				prev_stat_q <= cond;
				match_q     <= match;
			end
		end
	end

	always_comb begin
		result.current_mode     = mode_n;
		result.current_line     = line_n;
		result.line_match       = eval ? match : match_q;
		result.stat_interrupt   = edge_hit;
		result.vblank_interrupt = vblank_p;
		result.render_line      = render_p;
		result.frame_done       = frame_p;
		result.window_latched   = window_n;
	end

`ifndef SYNTHESIS
	a_line_dots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_dots_q < DotsPerLine)
		else $error("line dot count past line end");
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.frame_done |=> mode_q == MODE_OAM && line_q == '0 &&
		frame_dots_q == '0)
		else $error("frame wrap did not restart at line 0");
	a_render_hblank: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.render_line |=> mode_q == MODE_HBLANK)
		else $error("end of drawing did not enter hblank");
	a_disable_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && !tick_s1.display_enabled |=> mode_q == MODE_HBLANK && line_q == '0 &&
		line_dots_q == '0)
		else $error("disabled display not held at line 0 hblank");
`endif

endmodule
`default_nettype wire

// ===== src/lcd_mode_timing_controller_top.sv =====
// LCD mode timing controller: one dot tick per beat in, one status beat out
// for every tick. A tick enters the input register, is timed by the sequencer
// once the output register can take its result, and that result is captured
// there, so a beat may be accepted every cycle while out_stall is low; each
// result is driven from the output register. The single sequencer state update
// per beat sets that rate. Configuration writes are registered and apply from
// the next status evaluation. Depends on lmtc_pkg, lmtc_in_stage and lmtc_seq.
`default_nettype none
module lcd_mode_timing_controller_top
	import lmtc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [LineW-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             advance,
	input  wire logic             display_enabled,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            current_mode,
	output logic [LineW-1:0]      current_line,
	output logic                  line_match,
	output logic                  stat_interrupt,
	output logic                  vblank_interrupt,
	output logic                  render_line,
	output logic                  frame_done,
	output logic                  window_latched
);

	lmtc_tick_t   tick, tick_s1;
	lmtc_result_t result, result_s2;
	logic         valid_s1, take, step;

	assign tick.advance         = advance;
	assign tick.display_enabled = display_enabled;

	assign take = !out_valid || !out_stall;
	assign step = valid_s1 && take;

	lmtc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.tick     (tick),
		.take     (take),
		.valid_s1 (valid_s1),
		.tick_s1  (tick_s1)
	);

	lmtc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.tick_s1   (tick_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign current_mode     = result_s2.current_mode;
	assign current_line     = result_s2.current_line;
	assign line_match       = result_s2.line_match;
	assign stat_interrupt   = result_s2.stat_interrupt;
	assign vblank_interrupt = result_s2.vblank_interrupt;
	assign render_line      = result_s2.render_line;
	assign frame_done       = result_s2.frame_done;
	assign window_latched   = result_s2.window_latched;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for lcd_mode_timing_controller_top: directed and random dot ticks,
// including long enabled runs through the first scanlines, checked beat by beat.
// Depends on lmtc_pkg and the block's RTL.
`timescale 1ns / 100ps
module testbench;
	import lmtc_pkg::*;

	localparam int unsigned CycleLimit   = 2000000;
	localparam int          DrainLimit   = 20000;
	localparam int          SettleCycles = 4;
	localparam logic [1:0]  RegUnused    = 2'd3;

	typedef enum {STIM_MIXED, STIM_FRAME} stim_t;

	class dot_timing_tracker;
		logic [LineW-1:0]      cmp_line, win_top;
		logic [3:0]            stat_en;
		lmtc_mode_t            mode;
		logic [LineW-1:0]      line;
		logic [LineDotsW-1:0]  line_dots;
		logic [FrameDotsW-1:0] frame_dots;
		bit                    prev_cond, win_latch, match_flag;
		lmtc_result_t          pending_status[$];
		int errors, beats, ticks, off_ticks, wraps, vblanks, draw_ends, stat_irqs, latch_rises;

		function new();
			cmp_line   = '0;
			win_top    = '0;
			stat_en    = '0;
			mode       = MODE_OAM;
			line       = '0;
			line_dots  = '0;
			frame_dots = '0;
			prev_cond  = 1'b0;
			win_latch  = 1'b0;
			match_flag = 1'b0;
		endfunction

		function void report(string what);
			errors++;
			if (errors <= 40)
				$display("%0t mismatch: %s", $time, what);
		endfunction

		function void write_reg(logic [1:0] idx, logic [LineW-1:0] data);
			case (idx)
				REG_COMPARE_LINE: cmp_line = data;
				REG_STAT_ENABLES: stat_en = data[3:0];
				REG_WINDOW_TOP:   win_top = data;
				default: ;
			endcase
		endfunction

		function bit evaluate_stat();
			bit hit, cond, rise;
			hit  = (cmp_line == line);
			cond = (hit && stat_en[EnMatch]) ||
			       (mode == MODE_OAM && stat_en[EnOam]) ||
			       (mode == MODE_VBLANK && stat_en[EnVblank]) ||
			       (mode == MODE_HBLANK && stat_en[EnHblank]);
			rise       = cond && !prev_cond;
			prev_cond  = cond;
			match_flag = hit;
			return rise;
		endfunction

		function void take_tick(logic adv, logic en);
			lmtc_result_t want;
			bit latch_was;
			want      = '0;
			latch_was = win_latch;
			ticks++;
			if (!en) begin
				off_ticks++;
				line                = '0;
				mode                = MODE_HBLANK;
				want.stat_interrupt = evaluate_stat();
				frame_dots          = '0;
				line_dots           = '0;
			end else if (adv) begin
				frame_dots++;
				line_dots++;
				case (mode)
					MODE_OAM: if (line_dots == DotDrawStart) begin
						mode                = MODE_DRAW;
						want.stat_interrupt = evaluate_stat();
						if (line == win_top)
							win_latch = 1'b1;
					end
					MODE_DRAW: if (line_dots == DotDrawEnd) begin
						want.render_line    = 1'b1;
						mode                = MODE_HBLANK;
						want.stat_interrupt = evaluate_stat();
					end
					MODE_HBLANK: if (line_dots == DotsPerLine) begin
						line_dots = '0;
						line++;
						if (line == FirstVblankLine) begin
							want.vblank_interrupt = 1'b1;
							mode                  = MODE_VBLANK;
						end else begin
							mode = MODE_OAM;
						end
						want.stat_interrupt = evaluate_stat();
					end
					default: if (line_dots == DotsPerLine) begin
						win_latch = 1'b0;
						line_dots = '0;
						line++;
						if (frame_dots == DotsPerFrame) begin
							want.frame_done = 1'b1;
							frame_dots      = '0;
							line            = '0;
							mode            = MODE_OAM;
						end
						want.stat_interrupt = evaluate_stat();
					end
				endcase
			end
			want.current_mode   = mode;
			want.current_line   = line;
			want.line_match     = match_flag;
			want.window_latched = win_latch;
			wraps       += want.frame_done;
			vblanks     += want.vblank_interrupt;
			draw_ends   += want.render_line;
			stat_irqs   += want.stat_interrupt;
			latch_rises += (win_latch && !latch_was);
			pending_status.push_back(want);
		endfunction

		function void match_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("beat %0d %s got %0h expected %0h", beats, name, got, want));
		endfunction

		function void check_status(lmtc_result_t got);
			lmtc_result_t want;
			if (pending_status.size() == 0) begin
				report($sformatf("beat %0d arrived with no tick pending", beats));
			end else begin
				want = pending_status.pop_front();
				match_field("current_mode", got.current_mode, want.current_mode);
				match_field("current_line", got.current_line, want.current_line);
				match_field("line_match", got.line_match, want.line_match);
				match_field("stat_interrupt", got.stat_interrupt, want.stat_interrupt);
				match_field("vblank_interrupt", got.vblank_interrupt, want.vblank_interrupt);
				match_field("render_line", got.render_line, want.render_line);
				match_field("frame_done", got.frame_done, want.frame_done);
				match_field("window_latched", got.window_latched, want.window_latched);
			end
			beats++;
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [LineW-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             advance = 1'b0;
	logic             display_enabled = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       current_mode;
	logic [LineW-1:0] current_line;
	logic             line_match, stat_interrupt, vblank_interrupt;
	logic             render_line, frame_done, window_latched;

	int unsigned       cycles = 0;
	int                stall_left = 0;
	int                stall_style = 0;
	int                settings = 0;
	dot_timing_tracker model;

	lcd_mode_timing_controller_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.advance(advance), .display_enabled(display_enabled),
		.out_valid(out_valid), .out_stall(out_stall),
		.current_mode(current_mode), .current_line(current_line),
		.line_match(line_match), .stat_interrupt(stat_interrupt),
		.vblank_interrupt(vblank_interrupt), .render_line(render_line),
		.frame_done(frame_done), .window_latched(window_latched)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left  = $urandom_range(16, 400);
		end else begin
			stall_left--;
		end
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 6);
			default: out_stall <= ((cycles % 5) < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				model.take_tick(advance, display_enabled);
			if (out_valid && !out_stall)
				model.check_status({current_mode, current_line, line_match, stat_interrupt,
					vblank_interrupt, render_line, frame_done, window_latched});
		end
	end

	task automatic send_tick(logic adv, logic en);
		in_valid        <= 1'b1;
		advance         <= adv;
		display_enabled <= en;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_register(logic [1:0] idx, logic [LineW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		model.write_reg(idx, data);
	endtask

	task automatic configure(logic [7:0] cmp, logic [7:0] en, logic [7:0] top, bit poke_unused);
		if (poke_unused)
			write_register(RegUnused, 8'($urandom_range(0, 255)));
		write_register(REG_COMPARE_LINE, cmp);
		write_register(REG_STAT_ENABLES, en);
		write_register(REG_WINDOW_TOP, top);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (model.pending_status.size() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		if (model.pending_status.size() != 0)
			model.report($sformatf("%0d status beats never arrived",
				model.pending_status.size()));
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic run_phase(int count, stim_t style);
		int   burst_left, gap;
		logic adv, en;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap        = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
				if (gap > 0) begin
					in_valid        <= 1'b0;
					advance         <= 1'($urandom_range(0, 1));
					display_enabled <= 1'($urandom_range(0, 1));
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			if (style == STIM_FRAME) begin
				en  = 1'b1;
				adv = ($urandom_range(0, 31) != 0);
			end else begin
				en  = ($urandom_range(0, 63) != 0);
				adv = ($urandom_range(0, 3) != 0);
			end
			send_tick(adv, en);
		end
		drain();
	endtask

	function automatic logic [7:0] pick_line();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(0, 153));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		model = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(1'b0, 1'b1); send_tick(1'b1, 1'b1); send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0); send_tick(1'b1, 1'b0); send_tick(1'b1, 1'b1);
		drain();
		configure(8'h00, 8'hFF, 8'h00, 1'b1);
		send_tick(1'b1, 1'b1); send_tick(1'b0, 1'b1); send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0); send_tick(1'b1, 1'b0); send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1); send_tick(1'b0, 1'b1);
		drain();
		configure(8'hFF, 8'h00, 8'hFF, 1'b1);
		send_tick(1'b1, 1'b0); send_tick(1'b0, 1'b1); send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		drain();

		for (int p = 0; p < 6; p++) begin
			configure(pick_line(), 8'($urandom_range(0, 255)), pick_line(),
				1'($urandom_range(0, 1)));
			run_phase(130, STIM_MIXED);
		end

		configure(8'($urandom_range(0, 2)), 8'($urandom_range(0, 15)),
			8'($urandom_range(0, 1)), 1'b0);
		send_tick(1'b1, 1'b0);
		run_phase(300, STIM_FRAME);
		configure(8'($urandom_range(0, 2)), 8'($urandom_range(8, 15)),
			8'($urandom_range(0, 1)), 1'b0);
		run_phase(250, STIM_FRAME);

		for (int p = 0; p < 2; p++) begin
			configure(pick_line(), 8'($urandom_range(0, 255)), pick_line(), 1'b1);
			run_phase(75, STIM_MIXED);
		end

		$display("covered %0d ticks (%0d with display off) over %0d register settings",
			model.ticks, model.off_ticks, settings);
		$display("%0d frame wraps, %0d vblank entries, %0d drawing ends, %0d stat irqs, %0d latches",
			model.wraps, model.vblanks, model.draw_ends, model.stat_irqs, model.latch_rises);
		if (model.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
src/lmtc_pkg.sv
src/lmtc_in_stage.sv
src/lmtc_seq.sv
src/lcd_mode_timing_controller_top.sv
bench/testbench.sv
